// ===== design/frame_table_next_fit_allocator_macros.svh =====
// Assertion macros used by the frame table checker.
`ifndef FRAME_TABLE_NEXT_FIT_ALLOCATOR_MACROS_SVH
`define FRAME_TABLE_NEXT_FIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define FTNFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define FTNFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ftnfa_pkg.sv =====
// Types, codes and helpers for the frame table allocator.
package ftnfa_pkg;

  localparam int MAX_FRAMES_DEF  = 256;
  localparam int MAX_SHARERS_DEF = 255;

  localparam int CFG_W   = 9;
  localparam int FRAME_W = 8;
  localparam int OWNER_W = 16;
  localparam int CNT_W   = 8;
  localparam int TOTAL_W = 9;

  localparam logic [CFG_W-1:0]   FRAMES_PRESENT_RST = 9'd256;
  localparam logic [OWNER_W-1:0] NO_OWNER           = 16'hFFFF;

  typedef enum logic [2:0] {
    ACT_ALLOC  = 3'd0,
    ACT_LINK   = 3'd1,
    ACT_UNLINK = 3'd2,
    ACT_SETREF = 3'd3,
    ACT_QUERY  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FREE   = 3'd1,
    ST_RANGE     = 3'd2,
    ST_SATURATED = 3'd3,
    ST_UNUSED    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_READ,
    S_UPD,
    S_SEND
  } state_t;

  // One frame table entry.
  typedef struct packed {
    logic               refd;
    logic [OWNER_W-1:0] owner;
    logic [CNT_W-1:0]   cnt;
  } entry_t;

  localparam entry_t ENTRY_RST = '{refd: 1'b0, owner: NO_OWNER, cnt: '0};

  // One result item.
  typedef struct packed {
    logic [2:0]         status;
    logic [FRAME_W-1:0] frame;
    logic               busy;
    logic               shared;
    logic               refd;
    logic [OWNER_W-1:0] owner;
    logic [CNT_W-1:0]   total;
    logic [TOTAL_W-1:0] busy_total;
  } res_t;

  function automatic res_t make_res(status_t st, logic [FRAME_W-1:0] frame, entry_t e,
                                    logic [TOTAL_W-1:0] bt);
    res_t r;
    r.status     = st;
    r.frame      = frame;
    r.busy       = (e.cnt != '0);
    r.shared     = (e.cnt > 8'd1);
    r.refd       = e.refd;
    r.owner      = e.owner;
    r.total      = e.cnt;
    r.busy_total = bt;
    return r;
  endfunction

endpackage

// ===== design/ftnfa_mem.sv =====
// Frame table storage: one write port, one registered read port.
module ftnfa_mem #(
  parameter int DEPTH = ftnfa_pkg::MAX_FRAMES_DEF,
  parameter int AW    = $clog2(ftnfa_pkg::MAX_FRAMES_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  ftnfa_pkg::entry_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output ftnfa_pkg::entry_t rd_data
);

  ftnfa_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/ftnfa_ctrl.sv =====
// Sequencer: table clear, next-fit scan, read-modify-write of one frame entry.
module ftnfa_ctrl #(
  parameter int MAX_FRAMES  = ftnfa_pkg::MAX_FRAMES_DEF,
  parameter int MAX_SHARERS = ftnfa_pkg::MAX_SHARERS_DEF,
  localparam int FW = $clog2(MAX_FRAMES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ftnfa_pkg::CFG_W-1:0]   frames_present,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    action,
  input  logic [ftnfa_pkg::FRAME_W-1:0] frame_number,
  input  logic [ftnfa_pkg::OWNER_W-1:0] requester_id,
  input  logic                          referenced_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ftnfa_pkg::res_t               res,
  output logic                          mem_wr_en,
  output logic [FW-1:0]                 mem_wr_addr,
  output ftnfa_pkg::entry_t             mem_wr_data,
  output logic                          mem_rd_en,
  output logic [FW-1:0]                 mem_rd_addr,
  input  ftnfa_pkg::entry_t             mem_rd_data
);

  localparam int BW  = $clog2(MAX_FRAMES + 1);
  localparam int DCW = $clog2(BW + 1);
  localparam int CNT_LIM_I = (MAX_SHARERS > 255) ? 255 : MAX_SHARERS;
  localparam logic [ftnfa_pkg::CNT_W-1:0] CNT_LIM = ftnfa_pkg::CNT_W'(CNT_LIM_I);
  localparam logic [BW-1:0] FRAMES_TOP = BW'(MAX_FRAMES);
  localparam logic [FW-1:0] LAST_ADDR  = FW'(MAX_FRAMES - 1);

  ftnfa_pkg::state_t state, state_next;

  logic [2:0]                    act;
  logic [ftnfa_pkg::FRAME_W-1:0] fnum;
  logic [ftnfa_pkg::OWNER_W-1:0] req;
  logic                          refv;
  logic [BW-1:0]                 nlim;
  logic [BW-1:0]                 busy_cnt;
  logic [FW-1:0]                 last;
  logic                          last_valid;
  logic [BW-1:0]                 rem;
  logic [BW-1:0]                 dvd;
  logic [DCW-1:0]                div_cnt;
  logic [FW-1:0]                 scan_addr;
  logic [FW-1:0]                 chk_addr;
  logic                          chk_valid;
  logic [BW-1:0]                 left;
  logic [FW-1:0]                 clr_addr;

  logic [BW-1:0]     n_now;
  logic              f_out;
  logic              alloc_full;
  logic [BW-1:0]     last_inc;
  logic              need_mod;
  logic [FW-1:0]     start_direct;
  logic [BW-1:0]     busy_inc;
  logic [BW-1:0]     busy_dec;
  logic [BW-1:0]     scan_inc;
  logic [FW-1:0]     scan_wrap;
  logic              hit;
  logic [BW:0]       div_t;
  logic              div_ge;
  ftnfa_pkg::entry_t claim_e;
  ftnfa_pkg::entry_t upd_e;
  logic              upd_wr;
  logic [BW-1:0]     upd_busy;
  ftnfa_pkg::status_t upd_st;

  // Frame count in force, frames_present capped at the table depth.
  always_comb begin
    if (32'(frames_present) > MAX_FRAMES) begin
      n_now = FRAMES_TOP;
    end else begin
      n_now = BW'(frames_present);
    end
  end

  assign f_out      = (32'(frame_number) >= 32'(n_now));
  assign alloc_full = (n_now == '0) || (busy_cnt >= n_now);
  assign last_inc   = BW'(last) + BW'(1);
  assign need_mod   = last_valid && (last_inc > n_now);

  always_comb begin
    if (last_valid && (last_inc < n_now)) begin
      start_direct = FW'(last_inc);
    end else begin
      start_direct = '0;
    end
  end

  assign busy_inc  = (busy_cnt < FRAMES_TOP) ? busy_cnt + BW'(1) : busy_cnt;
  assign busy_dec  = (busy_cnt != '0) ? busy_cnt - BW'(1) : busy_cnt;
  assign scan_inc  = BW'(scan_addr) + BW'(1);
  assign scan_wrap = (scan_inc == nlim) ? '0 : FW'(scan_inc);
  assign hit       = chk_valid && (mem_rd_data.cnt == '0);

  // Restoring remainder step for the wrapped search start.
  assign div_t  = {rem, dvd[BW-1]};
  assign div_ge = (div_t >= {1'b0, nlim});

  always_comb begin
    claim_e       = mem_rd_data;
    claim_e.owner = req;
    claim_e.cnt   = 8'd1;
  end

  // Entry update for link, unlink, set referenced and query.
  always_comb begin
    upd_e    = mem_rd_data;
    upd_wr   = 1'b0;
    upd_busy = busy_cnt;
    upd_st   = ftnfa_pkg::ST_OK;
    case (act)
      ftnfa_pkg::ACT_LINK: begin
        if (mem_rd_data.cnt >= CNT_LIM) begin
          upd_st = ftnfa_pkg::ST_SATURATED;
        end else begin
          upd_e.cnt = mem_rd_data.cnt + 8'd1;
          upd_wr    = 1'b1;
          if (mem_rd_data.cnt == '0) begin
            upd_busy = busy_inc;
          end
        end
      end
      ftnfa_pkg::ACT_UNLINK: begin
        if (mem_rd_data.cnt == '0) begin
          upd_st = ftnfa_pkg::ST_UNUSED;
        end else begin
          upd_e.cnt = mem_rd_data.cnt - 8'd1;
          upd_wr    = 1'b1;
          if (mem_rd_data.cnt == 8'd1) begin
            upd_busy = busy_dec;
          end
        end
      end
      ftnfa_pkg::ACT_SETREF: begin
        upd_e.refd = refv;
        upd_wr     = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ftnfa_pkg::S_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = ftnfa_pkg::S_IDLE;
        end
      end
      ftnfa_pkg::S_IDLE: begin
        if (in_valid) begin
          if (action == ftnfa_pkg::ACT_ALLOC) begin
            if (alloc_full) begin
              state_next = ftnfa_pkg::S_SEND;
            end else if (need_mod) begin
              state_next = ftnfa_pkg::S_MOD;
            end else begin
              state_next = ftnfa_pkg::S_SCAN;
            end
          end else if (f_out) begin
            state_next = ftnfa_pkg::S_SEND;
          end else begin
            state_next = ftnfa_pkg::S_READ;
          end
        end
      end
      ftnfa_pkg::S_MOD: begin
        if (div_cnt == '0) begin
          state_next = ftnfa_pkg::S_SCAN;
        end
      end
      ftnfa_pkg::S_SCAN: begin
        if (hit || (left == '0)) begin
          state_next = ftnfa_pkg::S_SEND;
        end
      end
      ftnfa_pkg::S_READ: state_next = ftnfa_pkg::S_UPD;
      ftnfa_pkg::S_UPD:  state_next = ftnfa_pkg::S_SEND;
      ftnfa_pkg::S_SEND: begin
        if (res_ready) begin
          state_next = ftnfa_pkg::S_IDLE;
        end
      end
      default: state_next = ftnfa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == ftnfa_pkg::S_IDLE);
    res_valid   = (state == ftnfa_pkg::S_SEND);
    mem_rd_en   = 1'b0;
    mem_rd_addr = scan_addr;
    mem_wr_en   = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = ftnfa_pkg::ENTRY_RST;
    case (state)
      ftnfa_pkg::S_CLEAR: mem_wr_en = 1'b1;
      ftnfa_pkg::S_SCAN: begin
        if (hit) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = chk_addr;
          mem_wr_data = claim_e;
        end else if (left != '0) begin
          mem_rd_en = 1'b1;
        end
      end
      ftnfa_pkg::S_READ: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = FW'(fnum);
      end
      ftnfa_pkg::S_UPD: begin
        mem_wr_en   = upd_wr;
        mem_wr_addr = FW'(fnum);
        mem_wr_data = upd_e;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ftnfa_pkg::S_CLEAR;
      clr_addr   <= '0;
      busy_cnt   <= '0;
      last       <= '0;
      last_valid <= 1'b0;
      chk_valid  <= 1'b0;
      div_cnt    <= '0;
      left       <= '0;
    end else begin
      state <= state_next;
      case (state)
        ftnfa_pkg::S_CLEAR: clr_addr <= clr_addr + FW'(1);
        ftnfa_pkg::S_IDLE: begin
          if (in_valid) begin
            act       <= action;
            fnum      <= frame_number;
            req       <= requester_id;
            refv      <= referenced_value;
            nlim      <= n_now;
            scan_addr <= start_direct;
            left      <= n_now;
            chk_valid <= 1'b0;
            dvd       <= last_inc;
            rem       <= '0;
            div_cnt   <= DCW'(BW);
            if (action == ftnfa_pkg::ACT_ALLOC) begin
              res <= ftnfa_pkg::make_res(ftnfa_pkg::ST_NO_FREE, '0, ftnfa_pkg::ENTRY_RST,
                                         9'(busy_cnt));
            end else begin
              res <= ftnfa_pkg::make_res(ftnfa_pkg::ST_RANGE, frame_number,
                                         ftnfa_pkg::ENTRY_RST, 9'(busy_cnt));
            end
          end
        end
        ftnfa_pkg::S_MOD: begin
          if (div_cnt != '0) begin
            rem     <= div_ge ? BW'(div_t - {1'b0, nlim}) : BW'(div_t);
            dvd     <= dvd << 1;
            div_cnt <= div_cnt - DCW'(1);
          end else begin
            scan_addr <= FW'(rem);
          end
        end
        ftnfa_pkg::S_SCAN: begin
          if (hit) begin
            busy_cnt   <= busy_inc;
            last       <= chk_addr;
            last_valid <= 1'b1;
            chk_valid  <= 1'b0;
            res <= ftnfa_pkg::make_res(ftnfa_pkg::ST_OK, 8'(chk_addr), claim_e,
                                       9'(busy_inc));
          end else if (left != '0) begin
            chk_addr  <= scan_addr;
            chk_valid <= 1'b1;
            left      <= left - BW'(1);
            scan_addr <= scan_wrap;
          end else begin
            chk_valid <= 1'b0;
            res <= ftnfa_pkg::make_res(ftnfa_pkg::ST_NO_FREE, '0, ftnfa_pkg::ENTRY_RST,
                                       9'(busy_cnt));
          end
        end
        ftnfa_pkg::S_UPD: begin
          busy_cnt <= upd_busy;
          res      <= ftnfa_pkg::make_res(upd_st, fnum, upd_e, 9'(upd_busy));
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/frame_table_next_fit_allocator.sv =====
// Top level of the frame table allocator: config register, sequencer, table, result register.
// A table of MAX_FRAMES frame entries (sharer count, owner, referenced bit) held in one
// synchronous memory with a single read and a single write port; one item is worked at a
// time. After reset the block clears the table, one entry per cycle, before in_ready first
// rises; frames_present writes are taken at any time. Link, unlink, set referenced and
// query go through accept, table read, update and any write-back, and result; an
// out-of-range frame goes from accept straight to result. Allocate scans next-fit from the
// frame after the last one allocated, one entry per cycle through the read port, until a
// free frame is found or every frame in force has been probed. If frames_present has
// been lowered to or below the last allocated frame number, the wrapped start is first
// computed by a one-bit-per-cycle remainder. A finished result sits in the output
// register until out_ready, and in_ready rises again as soon as it has moved there.
module frame_table_next_fit_allocator #(
  parameter int MAX_FRAMES  = ftnfa_pkg::MAX_FRAMES_DEF,
  parameter int MAX_SHARERS = ftnfa_pkg::MAX_SHARERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ftnfa_pkg::CFG_W-1:0]   frames_present,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    action,
  input  logic [ftnfa_pkg::FRAME_W-1:0] frame_number,
  input  logic [ftnfa_pkg::OWNER_W-1:0] requester_id,
  input  logic                          referenced_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [ftnfa_pkg::FRAME_W-1:0] result_frame,
  output logic                          frame_busy,
  output logic                          frame_shared,
  output logic                          referenced_bit,
  output logic [ftnfa_pkg::OWNER_W-1:0] owner_id,
  output logic [ftnfa_pkg::CNT_W-1:0]   sharer_total,
  output logic [ftnfa_pkg::TOTAL_W-1:0] busy_total
);

  localparam int FW = $clog2(MAX_FRAMES);

  logic [ftnfa_pkg::CFG_W-1:0] frames_cfg;
  ftnfa_pkg::res_t             out_res;

  logic              res_valid;
  logic              res_ready;
  ftnfa_pkg::res_t   res;
  logic              mem_wr_en;
  logic [FW-1:0]     mem_wr_addr;
  ftnfa_pkg::entry_t mem_wr_data;
  logic              mem_rd_en;
  logic [FW-1:0]     mem_rd_addr;
  ftnfa_pkg::entry_t mem_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= ftnfa_pkg::FRAMES_PRESENT_RST;
    end else if (cfg_valid) begin
      frames_cfg <= frames_present;
    end
  end

  ftnfa_ctrl #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_SHARERS (MAX_SHARERS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .frames_present   (frames_cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .action           (action),
    .frame_number     (frame_number),
    .requester_id     (requester_id),
    .referenced_value (referenced_value),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .mem_wr_en        (mem_wr_en),
    .mem_wr_addr      (mem_wr_addr),
    .mem_wr_data      (mem_wr_data),
    .mem_rd_en        (mem_rd_en),
    .mem_rd_addr      (mem_rd_addr),
    .mem_rd_data      (mem_rd_data)
  );

  ftnfa_mem #(
    .DEPTH (MAX_FRAMES),
    .AW    (FW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register; takes a new result whenever it is empty or being drained.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign status         = out_res.status;
  assign result_frame   = out_res.frame;
  assign frame_busy     = out_res.busy;
  assign frame_shared   = out_res.shared;
  assign referenced_bit = out_res.refd;
  assign owner_id       = out_res.owner;
  assign sharer_total   = out_res.total;
  assign busy_total     = out_res.busy_total;

endmodule

// ===== design/ftnfa_chk.sv =====
// Port-level checker for the frame table allocator, bound to the top level.
`include "frame_table_next_fit_allocator_macros.svh"

module ftnfa_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [2:0]                    status,
  input logic [ftnfa_pkg::FRAME_W-1:0] result_frame,
  input logic                          frame_busy,
  input logic                          frame_shared,
  input logic [ftnfa_pkg::OWNER_W-1:0] owner_id,
  input logic [ftnfa_pkg::CNT_W-1:0]   sharer_total
);

  logic        flags_ok;
  logic        is_no_free;
  logic        no_free_blank;
  logic        is_range;
  logic        range_blank;
  logic [34:0] held;

  assign flags_ok      = (frame_busy == (sharer_total != 8'd0)) &&
                         (frame_shared == (sharer_total > 8'd1));
  assign is_no_free    = out_valid && (status == ftnfa_pkg::ST_NO_FREE);
  assign no_free_blank = (result_frame == 8'd0) && (sharer_total == 8'd0) &&
                         (owner_id == ftnfa_pkg::NO_OWNER);
  assign is_range      = out_valid && (status == ftnfa_pkg::ST_RANGE);
  assign range_blank   = (sharer_total == 8'd0) && (owner_id == ftnfa_pkg::NO_OWNER);
  assign held          = {status, result_frame, owner_id, sharer_total};

  // Busy and shared flags follow the reported count.
  `FTNFA_ASSERT_NOW(a_flags_match_count, out_valid, flags_ok, "flags disagree with count")

  // A failed allocate reports an empty, ownerless frame 0.
  `FTNFA_ASSERT_NOW(a_no_free_blank, is_no_free, no_free_blank, "no-free result not blank")

  // An out-of-range item touches nothing and reports no owner.
  `FTNFA_ASSERT_NOW(a_range_blank, is_range, range_blank, "out-of-range result not blank")

  // A stalled result holds.
  `FTNFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(held), "stall moved")

endmodule

bind frame_table_next_fit_allocator ftnfa_chk u_chk (.*);
